>>> hdl/ceh_pkg.sv
package ceh_pkg;

  // Default sizes of the block
  localparam int CEH_MODULUS_BITS = 12;
  localparam int CEH_BIN_COUNT    = 2048;
  localparam int CEH_COUNT_BITS   = 16;

  // Compression settings
  localparam int CEH_MAX_D      = 11;
  localparam int CEH_QUOT_BITS  = CEH_MAX_D + 1;
  localparam int CEH_DBITS_W    = 4;
  localparam int CEH_MODULUS_RST = 3329;
  localparam logic [CEH_DBITS_W-1:0] CEH_DBITS_RST = 4'd10;

  // Fixed widths of the result fields
  localparam int CEH_COMP_W   = 12;
  localparam int CEH_DECOMP_W = 12;
  localparam int CEH_ERR_W    = 11;

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } ceh_op_e;

  typedef enum logic [0:0] {
    CFG_MODULUS   = 1'b0,
    CFG_COMP_BITS = 1'b1
  } ceh_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ERR,
    ST_LOOK,
    ST_UPD,
    ST_DONE
  } ceh_state_e;

  // Status of the iterative divider
  typedef struct packed {
    logic busy;
    logic done;
  } ceh_div_stat_t;

endpackage

>>> hdl/ceh_div.sv
module ceh_div
  import ceh_pkg::*;
#(
  parameter int MODULUS_BITS = CEH_MODULUS_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [MODULUS_BITS+CEH_QUOT_BITS-1:0] numer_i,
  input  logic [MODULUS_BITS-1:0]              denom_i,
  output ceh_div_stat_t                        stat_o,
  output logic [CEH_QUOT_BITS-1:0]             quot_o
);

  localparam int QB = CEH_QUOT_BITS;
  localparam int NW = MODULUS_BITS + QB;
  localparam int CW = $clog2(QB);

  logic [MODULUS_BITS-1:0] rem_q, rem_d;
  logic [QB-1:0]           sh_q, sh_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [MODULUS_BITS:0]   trial;
  logic [MODULUS_BITS:0]   diff;
  logic                    ge;
  logic                    last;

  // One restoring step: shift in a numerator bit, trial subtract
  assign trial = {rem_q, sh_q[QB-1]};
  assign diff  = trial - {1'b0, denom_i};
  assign ge    = trial >= {1'b0, denom_i};
  assign last  = cnt_q == CW'(QB - 1);

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // Upper numerator bits are already below the divisor
      rem_d  = numer_i[NW-1:QB];
      sh_d   = numer_i[QB-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[MODULUS_BITS-1:0] : trial[MODULUS_BITS-1:0];
      sh_d  = {sh_q[QB-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = sh_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < denom_i)
    else $error("divider remainder not below divisor");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a running division");

endmodule

>>> hdl/ceh_hist.sv
module ceh_hist
  import ceh_pkg::*;
#(
  parameter int BIN_COUNT  = CEH_BIN_COUNT,
  parameter int COUNT_BITS = CEH_COUNT_BITS,
  localparam int AW = $clog2(BIN_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_data_i,
  output logic                  clr_busy_o
);

  logic [COUNT_BITS-1:0] mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  clr_q, clr_d;
  logic [AW-1:0]         clr_idx_q, clr_idx_d;

  // Sweep every bin to zero once after reset
  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      if (clr_idx_q == AW'(BIN_COUNT - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  // Single write port, shared by the sweep and count updates
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_q;

  a_no_access_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !wr_en_i && !rd_en_i)
    else $error("histogram accessed during clearing sweep");

endmodule

>>> hdl/compression_error_histogram.sv
// Record item: after accept it passes through DIV, MUL, ERR, LOOK, UPD and DONE, then back to IDLE.
// The iterative divider (one quotient bit per cycle, 12 steps) takes up most of a record item's work.
// Read item: LOOK, UPD and DONE; a refused residue or bin goes straight to DONE. One item is in work at a time.
// A finished result waits in the output register while the next item is accepted.
// Reset clears control state and then sweeps the histogram to zero, one bin per cycle;
// no item is accepted during the sweep, configuration writes are.
module compression_error_histogram
  import ceh_pkg::*;
#(
  parameter int MODULUS_BITS = CEH_MODULUS_BITS,
  parameter int BIN_COUNT    = CEH_BIN_COUNT,
  parameter int COUNT_BITS   = CEH_COUNT_BITS,
  localparam int CFG_W = (MODULUS_BITS > CEH_DBITS_W) ? MODULUS_BITS : CEH_DBITS_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_operation_i,
  input  logic [MODULUS_BITS-1:0] in_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CEH_COMP_W-1:0]   out_compressed_o,
  output logic [CEH_DECOMP_W-1:0] out_decompressed_o,
  output logic [CEH_ERR_W-1:0]    out_abs_error_o,
  output logic [COUNT_BITS-1:0]   out_bin_count_o,
  output logic                    out_rejected_o
);

  localparam int QB = CEH_QUOT_BITS;
  localparam int NW = MODULUS_BITS + QB;
  localparam int PW = MODULUS_BITS + QB;
  localparam int DW = MODULUS_BITS + 1;
  localparam int AW = $clog2(BIN_COUNT);

  // Configuration registers
  logic [MODULUS_BITS-1:0] modulus_q;
  logic [CEH_DBITS_W-1:0]  dbits_q;
  logic [MODULUS_BITS-1:0] q_eff;
  logic [CEH_DBITS_W-1:0]  d_eff;

  ceh_state_e state_q, state_d;

  // Item datapath
  ceh_op_e                 op_q;
  logic [MODULUS_BITS-1:0] v_q;
  logic [AW-1:0]           addr_q;
  logic [QB-1:0]           comp_q;
  logic [PW-1:0]           prod_q;
  logic [DW-1:0]           decomp_q;
  logic [DW-1:0]           err_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic                    rej_q;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [CEH_COMP_W-1:0]   out_comp_q;
  logic [CEH_DECOMP_W-1:0] out_decomp_q;
  logic [CEH_ERR_W-1:0]    out_err_q;
  logic [COUNT_BITS-1:0]   out_cnt_q;
  logic                    out_rej_q;

  logic                    in_acc;
  logic                    out_free;
  logic                    load_out;
  logic                    in_is_read;
  logic                    read_ok;
  logic                    rec_ok;
  logic                    div_start;
  logic [NW-1:0]           numer;
  ceh_div_stat_t           div_stat;
  logic [QB-1:0]           quot;
  logic [PW-1:0]           rnd;
  logic [PW-1:0]           decomp_full;
  logic [DW-1:0]           decomp;
  logic [DW-1:0]           err;
  logic                    err_ok;
  logic                    rd_en;
  logic                    wr_en;
  logic [COUNT_BITS-1:0]   rd_data;
  logic [COUNT_BITS-1:0]   cnt_new;
  logic                    clr_busy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_BITS'(CEH_MODULUS_RST);
      dbits_q   <= CEH_DBITS_RST;
    end else if (cfg_we_i) begin
      case (ceh_cfg_e'(cfg_idx_i))
        CFG_MODULUS:   modulus_q <= cfg_data_i[MODULUS_BITS-1:0];
        CFG_COMP_BITS: dbits_q   <= cfg_data_i[CEH_DBITS_W-1:0];
        default:       ;
      endcase
    end
  end

  // Clamp modulus and bit count to their usable range
  assign q_eff = (modulus_q < MODULUS_BITS'(3)) ? MODULUS_BITS'(3) : modulus_q;
  always_comb begin
    if (dbits_q == '0) begin
      d_eff = CEH_DBITS_W'(1);
    end else if (dbits_q > CEH_DBITS_W'(CEH_MAX_D)) begin
      d_eff = CEH_DBITS_W'(CEH_MAX_D);
    end else begin
      d_eff = dbits_q;
    end
  end

  // Input checks
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_is_read = ceh_op_e'(in_operation_i) == OP_READ;
  assign read_ok    = (in_value_i <= (q_eff >> 1)) && (32'(in_value_i) < 32'(BIN_COUNT));
  assign rec_ok     = in_value_i < q_eff;
  assign div_start  = in_acc && !in_is_read && rec_ok;

  // Numerator of the compression: x * 2^d + floor(q/2)
  assign numer = (NW'(in_value_i) << d_eff) + NW'(q_eff >> 1);

  ceh_div #(
    .MODULUS_BITS(MODULUS_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .numer_i(numer),
    .denom_i(q_eff),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  // Decompression and error
  assign rnd         = PW'(1) << (d_eff - CEH_DBITS_W'(1));
  assign decomp_full = prod_q >> d_eff;
  assign decomp      = decomp_full[DW-1:0];
  assign err         = (decomp >= DW'(v_q)) ? (decomp - DW'(v_q)) : (DW'(v_q) - decomp);
  assign err_ok      = 32'(err) < 32'(BIN_COUNT);

  // Saturating count update for a record; a read passes the count through
  assign cnt_new = (op_q == OP_READ) ? rd_data
                 : ((rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1));

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    in_stall_o = (state_q != ST_IDLE) || clr_busy;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_is_read) begin
            state_d = read_ok ? ST_LOOK : ST_DONE;
          end else begin
            state_d = rec_ok ? ST_DIV : ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ERR;
      ST_ERR: state_d = err_ok ? ST_LOOK : ST_DONE;
      ST_LOOK: begin
        rd_en   = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        wr_en   = op_q == OP_RECORD;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance item datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_q     <= ceh_op_e'(in_operation_i);
          v_q      <= in_value_i;
          addr_q   <= in_value_i[AW-1:0];
          comp_q   <= '0;
          decomp_q <= '0;
          err_q    <= '0;
          cnt_q    <= '0;
          rej_q    <= in_is_read ? !read_ok : !rec_ok;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          comp_q <= quot;
        end
      end
      ST_MUL: prod_q <= PW'(comp_q) * PW'(q_eff) + rnd;
      ST_ERR: begin
        decomp_q <= decomp;
        err_q    <= err;
        addr_q   <= err[AW-1:0];
        rej_q    <= !err_ok;
      end
      ST_UPD: cnt_q <= cnt_new;
      default: ;
    endcase
  end

  ceh_hist #(
    .BIN_COUNT (BIN_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (cnt_new),
    .clr_busy_o(clr_busy)
  );

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_comp_q   <= CEH_COMP_W'(comp_q);
      out_decomp_q <= CEH_DECOMP_W'(decomp_q);
      out_err_q    <= CEH_ERR_W'(err_q);
      out_cnt_q    <= cnt_q;
      out_rej_q    <= rej_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_compressed_o   = out_comp_q;
  assign out_decompressed_o = out_decomp_q;
  assign out_abs_error_o    = out_err_q;
  assign out_bin_count_o    = out_cnt_q;
  assign out_rejected_o     = out_rej_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("new item accepted while one is in work");

  a_mul_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> $past(state_q) == ST_DIV && $past(div_stat.done))
    else $error("multiply step entered without a finished division");

  a_reject_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rejected_o |-> out_bin_count_o == '0)
    else $error("refused item reports a bin count");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ceh_pkg::*;

  localparam int          BINS        = CEH_BIN_COUNT;
  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 103;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AT     = 150;
  localparam int          SETTLE      = 25;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CEH_COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    ceh_op_e                    op;
    logic [CEH_MODULUS_BITS-1:0] value;
  } item_t;

  typedef struct packed {
    logic [CEH_COMP_W-1:0]     compressed;
    logic [CEH_DECOMP_W-1:0]   decompressed;
    logic [CEH_ERR_W-1:0]      abs_error;
    logic [CEH_COUNT_BITS-1:0] bin_count;
    logic                      rejected;
  } result_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic                        cfg_idx_i      = 1'b0;
  logic [CEH_MODULUS_BITS-1:0] cfg_data_i     = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic                        in_operation_i = 1'b0;
  logic [CEH_MODULUS_BITS-1:0] in_value_i     = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic [CEH_COMP_W-1:0]       out_compressed_o;
  logic [CEH_DECOMP_W-1:0]     out_decompressed_o;
  logic [CEH_ERR_W-1:0]        out_abs_error_o;
  logic [CEH_COUNT_BITS-1:0]   out_bin_count_o;
  logic                        out_rejected_o;

  // Shadow of the block: histogram and register values
  logic [CEH_COUNT_BITS-1:0]   histogram [BINS];
  logic [CEH_MODULUS_BITS-1:0] modulus_reg = CEH_MODULUS_BITS'(CEH_MODULUS_RST);
  logic [CEH_DBITS_W-1:0]      dbits_reg   = CEH_DBITS_RST;

  item_t       pending_items[$];
  result_t     expected_results[$];
  item_t       offered;
  result_t     want;
  result_t     got;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned results_seen  = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  int unsigned mod_plan [PHASES] = '{4095, 3, 2, 0, 3329, 257, 4093, 17, 3329, 2053};
  int unsigned bits_plan[PHASES] = '{11, 1, 0, 15, 4, 12'hFFC, 5, 1, 10, 8};

  compression_error_histogram u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_operation_i     (in_operation_i),
    .in_value_i         (in_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_compressed_o   (out_compressed_o),
    .out_decompressed_o (out_decompressed_o),
    .out_abs_error_o    (out_abs_error_o),
    .out_bin_count_o    (out_bin_count_o),
    .out_rejected_o     (out_rejected_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned eff_modulus();
    return (modulus_reg < 3) ? 3 : modulus_reg;
  endfunction

  function automatic longint unsigned eff_dbits();
    if (dbits_reg < 1) return 1;
    return (dbits_reg > CEH_MAX_D) ? CEH_MAX_D : dbits_reg;
  endfunction

  // Compress, decompress and bin one item; updates the shadow histogram
  function automatic result_t compress_and_count(item_t it);
    longint unsigned q, d, v, y, z, e;
    result_t r;
    r = '0;
    q = eff_modulus();
    d = eff_dbits();
    v = it.value;
    if (it.op == OP_READ) begin
      if (v > q / 2 || v >= BINS) r.rejected = 1'b1;
      else r.bin_count = histogram[v];
    end else if (v >= q) begin
      r.rejected = 1'b1;
    end else begin
      y = ((v << d) + (q >> 1)) / q;
      z = (y * q + (64'd1 << (d - 1))) >> d;
      e = (z > v) ? z - v : v - z;
      r.compressed   = y[CEH_COMP_W-1:0];
      r.decompressed = z[CEH_DECOMP_W-1:0];
      r.abs_error    = e[CEH_ERR_W-1:0];
      if (e < BINS) begin
        if (histogram[e] != COUNT_MAX) histogram[e] = histogram[e] + 1'b1;
        r.bin_count = histogram[e];
      end else begin
        r.rejected = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic queue_item(ceh_op_e op, logic [CEH_MODULUS_BITS-1:0] val);
    item_t it;
    it.op    = op;
    it.value = val;
    pending_items.push_back(it);
  endtask

  // Wait until nothing is in flight, then let the block settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(ceh_cfg_e idx, logic [CEH_MODULUS_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_MODULUS) modulus_reg = data;
    else dbits_reg = data[CEH_DBITS_W-1:0];
  endtask

  // Sender: predict on accept, hold a stalled item, offer the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        offered.op    = ceh_op_e'(in_operation_i);
        offered.value = in_value_i;
        expected_results.push_back(compress_and_count(offered));
      end
      if (in_valid_i && in_stall_o !== 1'b0) begin
        // hold the stalled item
      end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_items.pop_front();
        in_valid_i     <= 1'b1;
        in_operation_i <= offered.op;
        in_value_i     <= offered.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: check each accepted result, then choose the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.compressed   = out_compressed_o;
        got.decompressed = out_decompressed_o;
        got.abs_error    = out_abs_error_o;
        got.bin_count    = out_bin_count_o;
        got.rejected     = out_rejected_o;
        results_seen++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: comp=%0d decomp=%0d err=%0d count=%0d rej=%0d",
                     got.compressed, got.decompressed, got.abs_error, got.bin_count,
                     got.rejected);
        end else begin
          want = expected_results.pop_front();
          if (got.compressed !== want.compressed || got.decompressed !== want.decompressed ||
              got.abs_error !== want.abs_error || got.bin_count !== want.bin_count ||
              got.rejected !== want.rejected) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch #%0d: exp comp=%0d decomp=%0d err=%0d count=%0d rej=%0d",
                       results_seen, want.compressed, want.decompressed, want.abs_error,
                       want.bin_count, want.rejected);
              $display("  got comp=%0d decomp=%0d err=%0d count=%0d rej=%0d",
                       got.compressed, got.decompressed, got.abs_error, got.bin_count,
                       got.rejected);
            end
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    longint unsigned q, d, span;
    int unsigned     sel;
    for (int i = 0; i < BINS; i++) histogram[i] = '0;
    mod_plan[8]  = $urandom_range(4095, 3);
    bits_plan[8] = $urandom_range(CEH_MAX_D, 1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, extremes, refusals, rounding up to 2^d
    queue_item(OP_RECORD, 12'd0);
    queue_item(OP_RECORD, 12'd3328);
    queue_item(OP_RECORD, 12'd3329);
    queue_item(OP_RECORD, 12'hFFF);
    queue_item(OP_RECORD, 12'd1);
    queue_item(OP_RECORD, 12'd1664);
    queue_item(OP_RECORD, 12'd1665);
    queue_item(OP_RECORD, 12'hAAA);
    queue_item(OP_RECORD, 12'h555);
    queue_item(OP_RECORD, 12'd3328);
    queue_item(OP_RECORD, 12'd100);
    queue_item(OP_READ,   12'd0);
    queue_item(OP_READ,   12'd1);
    queue_item(OP_READ,   12'd2);
    queue_item(OP_READ,   12'd1664);
    queue_item(OP_READ,   12'd1665);
    queue_item(OP_READ,   12'd2048);
    queue_item(OP_READ,   12'hFFF);
    queue_item(OP_READ,   12'hAAA);
    queue_item(OP_READ,   12'h555);

    // Random phases, each under new settings
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_MODULUS, CEH_MODULUS_BITS'(mod_plan[p]));
      write_reg(CFG_COMP_BITS, CEH_MODULUS_BITS'(bits_plan[p]));
      if (p < 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 50;
      end else if (p < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      q    = eff_modulus();
      d    = eff_dbits();
      span = (q >> (d + 1)) + 2;
      if (span > q / 2) span = q / 2;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(99);
        if (sel < 58) begin
          queue_item(OP_RECORD, CEH_MODULUS_BITS'($urandom_range(32'(q - 1), 0)));
        end else if (sel < 83) begin
          queue_item(OP_READ, CEH_MODULUS_BITS'($urandom_range(32'(span), 0)));
        end else if (sel < 93) begin
          queue_item(ceh_op_e'($urandom_range(1)), CEH_MODULUS_BITS'($urandom_range(4095)));
        end else begin
          // edges of the accepted ranges
          case ($urandom_range(3))
            0: queue_item(OP_RECORD, CEH_MODULUS_BITS'(q - 1));
            1: queue_item(OP_RECORD, CEH_MODULUS_BITS'(q));
            2: queue_item(OP_READ, CEH_MODULUS_BITS'(q / 2));
            default: queue_item(OP_READ, CEH_MODULUS_BITS'(q / 2 + 1));
          endcase
        end
      end
    end

    // Drain and let trailing results arrive
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> compression_error_histogram.f
hdl/ceh_pkg.sv
hdl/ceh_div.sv
hdl/ceh_hist.sv
hdl/compression_error_histogram.sv
sim/testbench.sv
